// ----- design/pftm_pkg.sv -----
// Shared types and constants of the perspective floor texel mapper.
`timescale 1ns / 1ps

package pftm_pkg;

	localparam int ZW = 8;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 24;

	localparam logic [CFG_IW-1:0] REG_COS   = 3'd0;
	localparam logic [CFG_IW-1:0] REG_SIN   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_CAMX  = 3'd2;
	localparam logic [CFG_IW-1:0] REG_CAMZ  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_SCALE = 3'd4;
	localparam logic [CFG_IW-1:0] REG_MAPW  = 3'd5;
	localparam logic [CFG_IW-1:0] REG_MAPH  = 3'd6;

	localparam logic [15:0] COS_RST   = 16'd16384;
	localparam logic [15:0] SIN_RST   = 16'd0;
	localparam logic [23:0] CAM_RST   = 24'd0;
	localparam logic [15:0] SCALE_RST = 16'd256;
	localparam logic [10:0] MAP_RST   = 11'd1024;

	localparam logic [8:0] DEPTH_OFS = 9'd100;

	typedef struct packed {
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [9:0] texel_x;
		logic [9:0] texel_y;
		logic       in_bounds;
	} texel_t;

endpackage

// ----- design/pftm_div.sv -----
// Pipelined floor divider by a small row distance, two quotient bits per stage.
`timescale 1ns / 1ps

module pftm_div #(
	parameter int QW = 29
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [QW-1:0]            num,
	input  logic                     neg,
	input  logic [pftm_pkg::ZW-1:0]  den,
	output logic signed [QW:0]       quo
);
	import pftm_pkg::*;

	localparam int NST = (QW + 1) / 2;
	localparam int QWP = 2 * NST;

	logic [QWP-1:0] num_s [NST];
	logic [ZW-1:0]  rem_s [NST];
	logic [ZW-1:0]  den_s [NST];
	logic           neg_s [NST];
	logic [QW-1:0]  q_mag;

	function automatic logic [QWP+ZW-1:0] div_step(
		input logic [QWP-1:0] n,
		input logic [ZW-1:0]  r,
		input logic [ZW-1:0]  d
	);
		logic [ZW:0]   t;
		logic [ZW:0]   diff;
		logic          qb;
		logic [ZW-1:0] r_n;
		t = {r, n[QWP-1]};
		diff = t - {1'b0, d};
		qb = (t >= {1'b0, d});
		r_n = qb ? diff[ZW-1:0] : t[ZW-1:0];
		return {r_n, n[QWP-2:0], qb};
	endfunction

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic [QWP-1:0]    n_in;
		logic [ZW-1:0]     r_in;
		logic [ZW-1:0]     d_in;
		logic              g_in;
		logic [QWP+ZW-1:0] st1;
		logic [QWP+ZW-1:0] st2;

		if (k == 0) begin : g_first
			assign n_in = QWP'(num);
			assign r_in = '0;
			assign d_in = den;
			assign g_in = neg;
		end else begin : g_next
			assign n_in = num_s[k-1];
			assign r_in = rem_s[k-1];
			assign d_in = den_s[k-1];
			assign g_in = neg_s[k-1];
		end

		always_comb begin
			st1 = div_step(n_in, r_in, d_in);
			st2 = div_step(st1[QWP-1:0], st1[QWP+ZW-1:QWP], d_in);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k] <= st2[QWP-1:0];
				rem_s[k] <= st2[QWP+ZW-1:QWP];
				den_s[k] <= d_in;
				neg_s[k] <= g_in;
			end
		end
	end

	// A negative dividend was divided in ones' complement, which turns the result into a floor.
	assign q_mag = num_s[NST-1][QW-1:0];
	assign quo = neg_s[NST-1] ? ~$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

endmodule

// ----- design/perspective_floor_texel_mapper_unit.sv -----
// Top level of the perspective floor texel mapper: config registers and the projection pipeline.
`timescale 1ns / 1ps

// The block maps one screen pixel per beat on the pix channel to one floor-map texel
// per beat on the texel channel, both valid/ready. Rows above the horizon and points
// off the map come out with in_bounds low and zero coordinates.
// The pipeline takes a new pixel every cycle while the output is not stalled. Each
// pixel passes stage 1, stages 2 to 4, the divider stages, stage 6 and the output
// register; QW is the quotient width of the row-distance divider (29 with the default
// screen size), which resolves two quotient bits per stage and so sets its depth.
// The camera heading, position, scale and map size are written on the cfg port at any
// index 0 to 6; other indexes are ignored. They are read live by the pipeline and
// must only change while no pixel is in flight.
// Reset clears all stage valid bits and loads the register defaults: heading zero,
// camera at the origin, unit scale and a 1024 by 1024 map.
// When the receiver holds texel_ready low with a beat waiting, the whole pipeline
// freezes in place and pix_ready drops; nothing is lost or repeated.
module perspective_floor_texel_mapper_unit #(
	parameter int SCREEN_W = 256,
	parameter int SCREEN_H = 224,
	parameter int MAP_MAX  = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  pftm_pkg::pixel_t              pix,
	output logic                          texel_valid,
	input  logic                          texel_ready,
	output pftm_pkg::texel_t              texel,
	input  logic                          cfg_we,
	input  logic [pftm_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [pftm_pkg::CFG_DW-1:0]   cfg_data
);
	import pftm_pkg::*;

	localparam int HALF_W = SCREEN_W / 2;
	localparam int HALF_H = SCREEN_H / 2;
	localparam int XW = ($clog2(SCREEN_W) + 1 > 9) ? $clog2(SCREEN_W) + 1 : 9;
	localparam int RW = ((XW + 16 > 26) ? XW + 16 : 26) + 1;
	localparam int NW = RW + 17;
	localparam int QW = RW + 2;
	localparam int DIV_ST = (QW + 1) / 2;
	localparam int PW = ((QW + 1 > 24) ? QW + 1 : 24) + 1;

	logic signed [15:0] cos_q;
	logic signed [15:0] sin_q;
	logic signed [23:0] camx_q;
	logic signed [23:0] camz_q;
	logic [15:0]        scale_q;
	logic [10:0]        mapw_q;
	logic [10:0]        maph_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q   <= COS_RST;
			sin_q   <= SIN_RST;
			camx_q  <= CAM_RST;
			camz_q  <= CAM_RST;
			scale_q <= SCALE_RST;
			mapw_q  <= MAP_RST;
			maph_q  <= MAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COS:   cos_q   <= cfg_data[15:0];
				REG_SIN:   sin_q   <= cfg_data[15:0];
				REG_CAMX:  camx_q  <= cfg_data[23:0];
				REG_CAMZ:  camz_q  <= cfg_data[23:0];
				REG_SCALE: scale_q <= cfg_data[15:0];
				REG_MAPW:  mapw_q  <= cfg_data[10:0];
				REG_MAPH:  maph_q  <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	logic en;

	assign en = !texel_valid || texel_ready;
	assign pix_ready = en;

	// Stage 1: view-space coordinates and the horizon test.
	logic signed [XW-1:0] x_d;
	logic [8:0]           y_d;
	logic [ZW-1:0]        z_raw;
	logic [ZW-1:0]        z_d;
	logic                 ok_d;

	always_comb begin
		x_d = $signed({{(XW-8){1'b0}}, pix.pixel_x}) - $signed(XW'(HALF_W));
		y_d = {1'b0, pix.pixel_y} + DEPTH_OFS;
		z_raw = pix.pixel_y - ZW'(HALF_H);
		z_d = (z_raw == '0) ? ZW'(1) : z_raw;
		ok_d = ({24'd0, pix.pixel_y} >= 32'(HALF_H));
	end

	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s6, vld_s7;
	logic                 ok_s1, ok_s2, ok_s3, ok_s4, ok_s6;
	logic signed [XW-1:0] x_s1;
	logic [8:0]           y_s1;
	logic [ZW-1:0]        z_s1, z_s2, z_s3, z_s4;

	logic signed [XW+15:0] xc_s2, xs_s2;
	logic signed [25:0]    yc_s2, ys_s2;
	logic signed [RW-1:0]  rx_s3, ry_s3;
	logic signed [NW-1:0]  nx_s4, ny_s4;

	logic                  vdiv_s [DIV_ST];
	logic                  okdiv_s [DIV_ST];

	logic signed [PW-1:0]  px_s6, py_s6;
	texel_t                out_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			for (int i = 0; i < DIV_ST; i++) begin
				vdiv_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s1 <= pix_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vdiv_s[0] <= vld_s4;
			for (int i = 1; i < DIV_ST; i++) begin
				vdiv_s[i] <= vdiv_s[i-1];
			end
			vld_s6 <= vdiv_s[DIV_ST-1];
			vld_s7 <= vld_s6;
		end
	end

	// Dividend for the divider: floor by 2^14, then ones' complement of negative values.
	logic signed [NW-15:0] ax_d, ay_d;
	logic [QW-1:0]         ux_d, uy_d;
	logic signed [QW:0]    qx, qy;

	always_comb begin
		ax_d = nx_s4[NW-1:14];
		ay_d = ny_s4[NW-1:14];
		ux_d = ax_d[QW] ? ~ax_d[QW-1:0] : ax_d[QW-1:0];
		uy_d = ay_d[QW] ? ~ay_d[QW-1:0] : ay_d[QW-1:0];
	end

	pftm_div #(.QW(QW)) u_div_x (
		.clk (clk),
		.en  (en),
		.num (ux_d),
		.neg (ax_d[QW]),
		.den (z_s4),
		.quo (qx)
	);

	pftm_div #(.QW(QW)) u_div_y (
		.clk (clk),
		.en  (en),
		.num (uy_d),
		.neg (ay_d[QW]),
		.den (z_s4),
		.quo (qy)
	);

	// Bounds check, rounding and row flip for the output register.
	logic [10:0]          w_eff, h_eff;
	logic signed [19:0]   lim_x, lim_y;
	logic                 inb_d;
	logic [19:0]          rnd_x, rnd_y;
	logic [10:0]          ty_raw;
	texel_t               out_d;

	always_comb begin
		w_eff = ({6'd0, mapw_q} > 17'(MAP_MAX)) ? 11'(MAP_MAX) : mapw_q;
		h_eff = ({6'd0, maph_q} > 17'(MAP_MAX)) ? 11'(MAP_MAX) : maph_q;
		lim_x = $signed({1'b0, w_eff, 8'd0}) - 20'sd256;
		lim_y = $signed({1'b0, h_eff, 8'd0}) - 20'sd256;
		inb_d = ok_s6 && !px_s6[PW-1] && !py_s6[PW-1]
			&& !(px_s6 > PW'(lim_x)) && !(py_s6 > PW'(lim_y));
		rnd_x = {1'b0, px_s6[18:0]} + 20'd128;
		rnd_y = {1'b0, py_s6[18:0]} + 20'd128;
		ty_raw = rnd_y[18:8];
		out_d.in_bounds = inb_d;
		out_d.texel_x = inb_d ? rnd_x[17:8] : 10'd0;
		out_d.texel_y = inb_d ? 10'(h_eff - 11'd1 - ty_raw) : 10'd0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= x_d;
			y_s1  <= y_d;
			z_s1  <= z_d;
			ok_s1 <= ok_d;

			xc_s2 <= x_s1 * cos_q;
			xs_s2 <= x_s1 * sin_q;
			yc_s2 <= $signed({1'b0, y_s1}) * cos_q;
			ys_s2 <= $signed({1'b0, y_s1}) * sin_q;
			z_s2  <= z_s1;
			ok_s2 <= ok_s1;

			rx_s3 <= RW'(xc_s2) + RW'(ys_s2);
			ry_s3 <= RW'(yc_s2) - RW'(xs_s2);
			z_s3  <= z_s2;
			ok_s3 <= ok_s2;

			nx_s4 <= rx_s3 * $signed({1'b0, scale_q});
			ny_s4 <= ry_s3 * $signed({1'b0, scale_q});
			z_s4  <= z_s3;
			ok_s4 <= ok_s3;

			okdiv_s[0] <= ok_s4;
			for (int i = 1; i < DIV_ST; i++) begin
				okdiv_s[i] <= okdiv_s[i-1];
			end

			px_s6  <= PW'(qx) + PW'(camx_q);
			py_s6  <= PW'(qy) + PW'(camz_q);
			ok_s6  <= okdiv_s[DIV_ST-1];

			out_s7 <= out_d;
		end
	end

	assign texel_valid = vld_s7;
	assign texel = out_s7;

endmodule
